// ===== design/dfr_pkg.sv =====
// Shared types and constants of the framed command deframer.
package dfr_pkg;

  localparam int unsigned CMD_BYTES       = 3;
  localparam int unsigned CODE_LANES_LOW  = 8;
  localparam int unsigned CODE_LANES_HIGH = 2;
  localparam int unsigned CFG_INDEX_W     = 3;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_START_CODE          = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STOP_CODE           = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLY_CODE          = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_UPLOAD_INFO_CODE    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEPTED_CODES_LOW  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEPTED_CODES_HIGH = 3'd5;

  typedef enum logic [1:0] {
    KIND_PARAM  = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_DROP   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_CTRL  = 3'd1,
    PH_LENH  = 3'd2,
    PH_LENL  = 3'd3,
    PH_DATA  = 3'd4,
    PH_SUM   = 3'd5,
    PH_STOP  = 3'd6
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  param_byte;
    logic [23:0] command;
    logic [15:0] param_count;
  } result_t;

  typedef struct packed {
    logic [7:0]  start_code;
    logic [7:0]  stop_code;
    logic [7:0]  reply_code;
    logic [7:0]  upload_info_code;
    logic [63:0] accepted_codes_low;
    logic [15:0] accepted_codes_high;
  } cfg_t;

endpackage

// ===== design/dfr_if.sv =====
// Handshake channel interfaces for received bytes and for results.
interface dfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface dfr_out_if;
  logic          valid;
  logic          ready;
  dfr_pkg::kind_t kind;
  logic [7:0]    param_byte;
  logic [23:0]   command;
  logic [15:0]   param_count;

  modport source (output valid, output kind, output param_byte, output command,
                  output param_count, input ready);
  modport sink (input valid, input kind, input param_byte, input command,
                input param_count, output ready);
endinterface

// ===== design/dfr_front.sv =====
// Front end: configuration registers, frame tracking and classification of each byte.
module dfr_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dfr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dfr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                byte_valid,
  input  logic [7:0]                          byte_data,
  input  logic                                queue_full,
  output logic                                byte_ready,
  output logic                                res_push,
  output dfr_pkg::result_t                    res_data
);

  dfr_pkg::cfg_t   cfg_r;
  dfr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      sum_r, sum_nxt;
  logic [15:0]     remaining_r, remaining_nxt;
  logic [15:0]     frame_len_r, frame_len_nxt;
  logic [23:0]     command_r, command_nxt;
  logic [1:0]      cmd_cnt_r, cmd_cnt_nxt;
  logic [7:0]      control_r, control_nxt;
  logic            take;
  logic            code_ok;
  logic [15:0]     len_full;
  logic            res_valid;
  dfr_pkg::result_t res;

  assign byte_ready = !queue_full;
  assign take       = byte_valid && byte_ready;
  assign len_full   = {frame_len_r[15:8], byte_data};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code          <= 8'd2;
      cfg_r.stop_code           <= 8'd3;
      cfg_r.reply_code          <= 8'd0;
      cfg_r.upload_info_code    <= 8'd0;
      cfg_r.accepted_codes_low  <= 64'd0;
      cfg_r.accepted_codes_high <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dfr_pkg::REG_START_CODE:          cfg_r.start_code <= cfg_wdata[7:0];
        dfr_pkg::REG_STOP_CODE:           cfg_r.stop_code <= cfg_wdata[7:0];
        dfr_pkg::REG_REPLY_CODE:          cfg_r.reply_code <= cfg_wdata[7:0];
        dfr_pkg::REG_UPLOAD_INFO_CODE:    cfg_r.upload_info_code <= cfg_wdata[7:0];
        dfr_pkg::REG_ACCEPTED_CODES_LOW:  cfg_r.accepted_codes_low <= cfg_wdata;
        dfr_pkg::REG_ACCEPTED_CODES_HIGH: cfg_r.accepted_codes_high <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    code_ok = 1'b0;
    for (int k = 0; k < int'(dfr_pkg::CODE_LANES_LOW); k++) begin
      if (cfg_r.accepted_codes_low[8*k +: 8] == byte_data) begin
        code_ok = 1'b1;
      end
    end
    for (int k = 0; k < int'(dfr_pkg::CODE_LANES_HIGH); k++) begin
      if (cfg_r.accepted_codes_high[8*k +: 8] == byte_data) begin
        code_ok = 1'b1;
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    if (take) begin
      unique case (phase_r)
        dfr_pkg::PH_CTRL: begin
          phase_nxt = code_ok ? dfr_pkg::PH_LENH : dfr_pkg::PH_START;
        end
        dfr_pkg::PH_LENH: begin
          phase_nxt = dfr_pkg::PH_LENL;
        end
        dfr_pkg::PH_LENL: begin
          phase_nxt = (len_full < 16'(dfr_pkg::CMD_BYTES)) ? dfr_pkg::PH_START
                                                            : dfr_pkg::PH_DATA;
        end
        dfr_pkg::PH_DATA: begin
          phase_nxt = (remaining_r == 16'd1) ? dfr_pkg::PH_SUM : dfr_pkg::PH_DATA;
        end
        dfr_pkg::PH_SUM: begin
          phase_nxt = (sum_r == byte_data) ? dfr_pkg::PH_STOP : dfr_pkg::PH_START;
        end
        dfr_pkg::PH_STOP: begin
          phase_nxt = dfr_pkg::PH_START;
        end
        default: begin
          phase_nxt = (byte_data == cfg_r.start_code) ? dfr_pkg::PH_CTRL
                                                      : dfr_pkg::PH_START;
        end
      endcase
    end
  end

  always_comb begin
    sum_nxt           = sum_r;
    remaining_nxt     = remaining_r;
    frame_len_nxt     = frame_len_r;
    command_nxt       = command_r;
    cmd_cnt_nxt       = cmd_cnt_r;
    control_nxt       = control_r;
    res_valid         = 1'b0;
    res.kind          = dfr_pkg::KIND_DROP;
    res.param_byte    = 8'd0;
    res.command       = 24'd0;
    res.param_count   = 16'd0;
    if (take) begin
      unique case (phase_r)
        dfr_pkg::PH_CTRL: begin
          if (code_ok) begin
            control_nxt = byte_data;
            sum_nxt     = byte_data;
          end
        end
        dfr_pkg::PH_LENH: begin
          sum_nxt       = sum_r + byte_data;
          frame_len_nxt = {byte_data, 8'd0};
        end
        dfr_pkg::PH_LENL: begin
          frame_len_nxt = len_full;
          if (len_full < 16'(dfr_pkg::CMD_BYTES)) begin
            res_valid = 1'b1;
          end else begin
            sum_nxt       = sum_r + byte_data;
            remaining_nxt = len_full;
            command_nxt   = 24'd0;
            cmd_cnt_nxt   = 2'd0;
          end
        end
        dfr_pkg::PH_DATA: begin
          sum_nxt       = sum_r + byte_data;
          remaining_nxt = remaining_r - 16'd1;
          if (cmd_cnt_r < 2'(dfr_pkg::CMD_BYTES)) begin
            command_nxt = {command_r[15:0], byte_data};
            cmd_cnt_nxt = cmd_cnt_r + 2'd1;
          end else begin
            res_valid      = 1'b1;
            res.kind       = dfr_pkg::KIND_PARAM;
            res.param_byte = byte_data;
          end
        end
        dfr_pkg::PH_SUM: begin
          res_valid = (sum_r != byte_data);
        end
        dfr_pkg::PH_STOP: begin
          if (byte_data != cfg_r.stop_code) begin
            res_valid = 1'b1;
          end else if (control_r == cfg_r.reply_code ||
                       control_r == cfg_r.upload_info_code) begin
            res_valid       = 1'b1;
            res.kind        = dfr_pkg::KIND_ACCEPT;
            res.command     = command_r;
            res.param_count = frame_len_r - 16'(dfr_pkg::CMD_BYTES);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dfr_pkg::PH_START;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= 8'd0;
      remaining_r <= 16'd0;
      frame_len_r <= 16'd0;
      command_r   <= 24'd0;
      cmd_cnt_r   <= 2'd0;
      control_r   <= 8'd0;
    end else begin
      sum_r       <= sum_nxt;
      remaining_r <= remaining_nxt;
      frame_len_r <= frame_len_nxt;
      command_r   <= command_nxt;
      cmd_cnt_r   <= cmd_cnt_nxt;
      control_r   <= control_nxt;
    end
  end

  assign res_push = res_valid;
  assign res_data = res;

endmodule

// ===== design/dfr_queue.sv =====
// Short result queue between the front end and the output stage.
module dfr_queue #(
  parameter int unsigned DEPTH = dfr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  dfr_pkg::result_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output dfr_pkg::result_t head_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  dfr_pkg::result_t   slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = slots[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/dfr_back.sv =====
// Output stage: takes results from the queue into a register that drives the result channel.
module dfr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  dfr_pkg::result_t head_data,
  output logic             pop,
  dfr_out_if.source        out_ch
);

  logic             out_valid_r, out_valid_nxt;
  dfr_pkg::result_t out_data_r;
  logic             load;

  assign load          = !out_valid_r || out_ch.ready;
  assign pop           = load && head_valid;
  assign out_valid_nxt = load ? head_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= head_data;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_data_r.kind;
  assign out_ch.param_byte  = out_data_r.param_byte;
  assign out_ch.command     = out_data_r.command;
  assign out_ch.param_count = out_data_r.param_count;

endmodule

// ===== design/framed_command_deframer.sv =====
// Top level of the framed command deframer: front end, result queue and output stage.
//
//   Channel   Direction  Contents
//   in_ch     sink       rx_byte, one received byte per request
//   out_ch    source     kind, param_byte, command, param_count
//   cfg_*     write      cfg_we, cfg_index (0 to 5), cfg_wdata (64 bits)
//
// One byte is taken every cycle while the result queue has room; each byte is
// classified combinationally by the frame tracking logic in the front end as
// it is taken. A result is written into the queue and then loaded into the
// output register that drives out_ch. Reset is synchronous and clears the
// frame state, the configuration, the queue and the output valid flag.
// A stalled result channel fills the queue, after which in_ch.ready falls.
module framed_command_deframer #(
  parameter int unsigned QUEUE_DEPTH = dfr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dfr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  dfr_in_if.sink                          in_ch,
  dfr_out_if.source                       out_ch
);

  logic             queue_full;
  logic             res_push;
  dfr_pkg::result_t res_data;
  logic             head_valid;
  dfr_pkg::result_t head_data;
  logic             pop;

  dfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .byte_valid (in_ch.valid),
    .byte_data  (in_ch.rx_byte),
    .queue_full (queue_full),
    .byte_ready (in_ch.ready),
    .res_push   (res_push),
    .res_data   (res_data)
  );

  dfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_push),
    .push_data  (res_data),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  dfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
